@@ design/dedup_digest_ring_table_unit_macros.svh @@
// assertion macros for the dedup digest ring table
`ifndef DEDUP_DIGEST_RING_TABLE_UNIT_MACROS_SVH
`define DEDUP_DIGEST_RING_TABLE_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define DDRT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define DDRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DDRT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define DDRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ design/ddrt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddrt_pkg
// shared types and constants of the dedup digest ring table
// ----------------------------------------------------------------------------
package ddrt_pkg;

    localparam int ENTRIES = 1024;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = IDX_W + 1;
    localparam int BLK_W   = 32;
    localparam int WCNT_W  = 11;
    localparam int DUP_W   = 10;
    localparam int DIG_W   = 256;
    localparam int WORD_W  = 64;
    localparam int CRC_W   = 32;
    localparam logic [DUP_W-1:0] DUP_MAX = {DUP_W{1'b1}};
    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB88320;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_LINK   = 2'd1,
        OP_UPDATE = 2'd2,
        OP_QUERY  = 2'd3
    } opcode_t;

    localparam logic CFG_WINDOW_START = 1'b0;
    localparam logic CFG_WINDOW_COUNT = 1'b1;

    typedef struct packed {
        logic             valid;
        logic [CRC_W-1:0] crc;
        logic [DIG_W-1:0] digest;
    } entry_t;

    typedef struct packed {
        logic             ent_re;
        logic [IDX_W-1:0] ent_raddr;
        logic             ent_we;
        logic [IDX_W-1:0] ent_waddr;
        entry_t           ent_wdata;
        logic             nxt_re;
        logic [IDX_W-1:0] nxt_raddr;
        logic             nxt_we;
        logic [IDX_W-1:0] nxt_waddr;
        logic [IDX_W-1:0] nxt_wdata;
    } tbl_req_t;

    typedef struct packed {
        entry_t           ent_rdata;
        logic [IDX_W-1:0] nxt_rdata;
    } tbl_rsp_t;

endpackage

@@ design/ddrt_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddrt channel interfaces
// valid/ready channels for commands and results
// ----------------------------------------------------------------------------
interface ddrt_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [31:0] block_number;
    logic [63:0] digest_word0;
    logic [63:0] digest_word1;
    logic [63:0] digest_word2;
    logic [63:0] digest_word3;

    modport source (output valid, opcode, block_number, digest_word0, digest_word1,
                    digest_word2, digest_word3, input ready);
    modport sink (input valid, opcode, block_number, digest_word0, digest_word1,
                  digest_word2, digest_word3, output ready);
endinterface

interface ddrt_res_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic        match_found;
    logic [31:0] matched_block;
    logic [31:0] next_block;
    logic [9:0]  duplicate_count;

    modport source (output valid, status, match_found, matched_block, next_block,
                    duplicate_count, input ready);
    modport sink (input valid, status, match_found, matched_block, next_block,
                  duplicate_count, output ready);
endinterface

@@ design/ddrt_crc.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddrt_crc
// serial reflected crc-32 poly, zero init, 256-bit digest, one byte per cycle
// ----------------------------------------------------------------------------
module ddrt_crc (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [ddrt_pkg::DIG_W-1:0]       data,
    output logic                             done,
    output logic [ddrt_pkg::CRC_W-1:0]       crc
);

    localparam int NBYTES = ddrt_pkg::DIG_W / 8;
    localparam int BC_W   = $clog2(NBYTES);

    logic [ddrt_pkg::DIG_W-1:0] sh_reg;
    logic [ddrt_pkg::CRC_W-1:0] crc_reg;
    logic [BC_W-1:0]            cnt_reg;
    logic                       run_reg;
    logic                       done_reg;

    function automatic logic [ddrt_pkg::CRC_W-1:0] crc_byte(
        input logic [ddrt_pkg::CRC_W-1:0] c_in,
        input logic [7:0]                 b);
        logic [ddrt_pkg::CRC_W-1:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ ddrt_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == BC_W'(NBYTES - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg  <= data;
            crc_reg <= '0;
        end
        else if (run_reg)
        begin
            sh_reg  <= sh_reg >> 8;
            crc_reg <= crc_byte(crc_reg, sh_reg[7:0]);
        end
    end

    assign done = done_reg;
    assign crc  = crc_reg;

endmodule

@@ design/ddrt_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddrt_table
// entry memory (valid, crc, digest) and next-equal memory, registered reads
// ----------------------------------------------------------------------------
module ddrt_table (
    input  logic               clk,
    input  ddrt_pkg::tbl_req_t req,
    output ddrt_pkg::tbl_rsp_t rsp
);

    ddrt_pkg::entry_t             ent_mem [ddrt_pkg::ENTRIES];
    logic [ddrt_pkg::IDX_W-1:0]   nxt_mem [ddrt_pkg::ENTRIES];
    ddrt_pkg::entry_t             ent_rdata_reg;
    logic [ddrt_pkg::IDX_W-1:0]   nxt_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.ent_we)
        begin
            ent_mem[req.ent_waddr] <= req.ent_wdata;
        end
        if (req.ent_re)
        begin
            ent_rdata_reg <= ent_mem[req.ent_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.nxt_we)
        begin
            nxt_mem[req.nxt_waddr] <= req.nxt_wdata;
        end
        if (req.nxt_re)
        begin
            nxt_rdata_reg <= nxt_mem[req.nxt_raddr];
        end
    end

    assign rsp.ent_rdata = ent_rdata_reg;
    assign rsp.nxt_rdata = nxt_rdata_reg;

endmodule

@@ design/dedup_digest_ring_table_unit.sv @@
// query reads the next link; load runs the crc, then writes the entry; link scans
// entries below idx (one table entry a cycle); update walks the ring (one hop a
// cycle), runs the crc and a window scan; one transaction at a time, the table
// memory ports set the pace; reset: valid marks are cleared by a sweep of all
// entries, commands wait until it ends; window and duplicate counter reset at once
`timescale 1ns / 1ps
`include "dedup_digest_ring_table_unit_macros.svh"
// ----------------------------------------------------------------------------
// dedup_digest_ring_table_unit
// digest dedup table with equal-digest rings over a window of blocks
// ----------------------------------------------------------------------------
module dedup_digest_ring_table_unit (
    input  logic              clk,
    input  logic              rst_n,
    ddrt_cmd_if.sink          cmd,
    ddrt_res_if.source        res,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [31:0]       cfg_wdata
);

    localparam int IW = ddrt_pkg::IDX_W;
    localparam int CW = ddrt_pkg::CNT_W;
    localparam int BW = ddrt_pkg::BLK_W;

    typedef enum logic [11:0] {
        S_CLEAR    = 12'b000000000001,
        S_IDLE     = 12'b000000000010,
        S_CRC      = 12'b000000000100,
        S_SELF     = 12'b000000001000,
        S_SCAN     = 12'b000000010000,
        S_JOIN_WR  = 12'b000000100000,
        S_JOIN_WR2 = 12'b000001000000,
        S_U_CHK    = 12'b000010000000,
        S_WALK     = 12'b000100000000,
        S_UNL2     = 12'b001000000000,
        S_Q_WAIT   = 12'b010000000000,
        S_SPARE    = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    logic [BW-1:0]                     ws_reg;
    logic [ddrt_pkg::WCNT_W-1:0]       wc_reg;
    logic [ddrt_pkg::DUP_W-1:0]        dup_reg, dup_next;
    logic [IW-1:0]                     clr_reg, clr_next;
    ddrt_pkg::opcode_t                 op_reg, op_next;
    logic [IW-1:0]                     idx_reg, idx_next;
    logic [ddrt_pkg::DIG_W-1:0]        dig_reg, dig_next;
    logic                              sv_reg, sv_next;
    logic [ddrt_pkg::CRC_W-1:0]        scrc_reg, scrc_next;
    logic [ddrt_pkg::DIG_W-1:0]        sdig_reg, sdig_next;
    logic [IW-1:0]                     snext_reg, snext_next;
    logic [CW-1:0]                     jis_reg, jis_next;
    logic [CW-1:0]                     lim_reg, lim_next;
    logic [CW-1:0]                     cnt_reg, cnt_next;
    logic                              pend_reg, pend_next;
    logic [IW-1:0]                     pj_reg, pj_next;
    logic [IW-1:0]                     mj_reg, mj_next;
    logic [IW-1:0]                     after_reg, after_next;
    logic [IW-1:0]                     cur_reg, cur_next;
    logic [IW-1:0]                     walk_reg, walk_next;

    logic                              rv_reg, rv_next;
    logic                              rst_reg, rst_next;
    logic                              rm_reg, rm_next;
    logic [BW-1:0]                     rmb_reg, rmb_next;
    logic [BW-1:0]                     rnb_reg, rnb_next;
    logic [ddrt_pkg::DUP_W-1:0]        rdup_reg, rdup_next;

    ddrt_pkg::tbl_req_t                treq;
    ddrt_pkg::tbl_rsp_t                trsp;

    logic                              crc_start;
    logic [ddrt_pkg::DIG_W-1:0]        crc_data;
    logic                              crc_done;
    logic [ddrt_pkg::CRC_W-1:0]        crc_val;

    logic                              accept;
    logic [BW-1:0]                     wcount;
    logic [BW-1:0]                     offs;
    logic                              in_win;
    logic [ddrt_pkg::DIG_W-1:0]        cmd_dig;
    logic                              hit;

    ddrt_table u_table (
        .clk (clk),
        .req (treq),
        .rsp (trsp)
    );

    ddrt_crc u_crc (
        .clk   (clk),
        .rst_n (rst_n),
        .start (crc_start),
        .data  (crc_data),
        .done  (crc_done),
        .crc   (crc_val)
    );

    assign cmd.ready = (state_reg == S_IDLE) && (!rv_reg || res.ready);
    assign accept    = cmd.valid && cmd.ready;
    assign cmd_dig   = {cmd.digest_word3, cmd.digest_word2, cmd.digest_word1,
                        cmd.digest_word0};
    assign wcount    = (BW'(wc_reg) > BW'(ddrt_pkg::ENTRIES)) ? BW'(ddrt_pkg::ENTRIES)
                                                              : BW'(wc_reg);
    assign offs      = cmd.block_number - ws_reg;
    assign in_win    = (cmd.block_number >= ws_reg) && (offs < wcount);
    assign crc_data  = (state_reg == S_IDLE) ? cmd_dig : dig_reg;

    // candidate compare on the entry read out last cycle
    assign hit = pend_reg && sv_reg && trsp.ent_rdata.valid
                 && (trsp.ent_rdata.crc == scrc_reg)
                 && (trsp.ent_rdata.digest == sdig_reg)
                 && !((op_reg == ddrt_pkg::OP_UPDATE) && (pj_reg == idx_reg));

    always_comb
    begin
        state_next = state_reg;
        dup_next   = dup_reg;
        clr_next   = clr_reg;
        op_next    = op_reg;
        idx_next   = idx_reg;
        dig_next   = dig_reg;
        sv_next    = sv_reg;
        scrc_next  = scrc_reg;
        sdig_next  = sdig_reg;
        snext_next = snext_reg;
        jis_next   = jis_reg;
        lim_next   = lim_reg;
        cnt_next   = cnt_reg;
        pend_next  = pend_reg;
        pj_next    = pj_reg;
        mj_next    = mj_reg;
        after_next = after_reg;
        cur_next   = cur_reg;
        walk_next  = walk_reg;
        rv_next    = rv_reg && !res.ready;
        rst_next   = rst_reg;
        rm_next    = rm_reg;
        rmb_next   = rmb_reg;
        rnb_next   = rnb_reg;
        rdup_next  = rdup_reg;
        crc_start  = 1'b0;
        treq       = '0;

        case (state_reg)
            S_CLEAR:
            begin
                treq.ent_we    = 1'b1;
                treq.ent_waddr = clr_reg;
                clr_next       = clr_reg + 1'b1;
                if (clr_reg == IW'(ddrt_pkg::ENTRIES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next  = ddrt_pkg::opcode_t'(cmd.opcode);
                    idx_next = offs[IW-1:0];
                    dig_next = cmd_dig;
                    cnt_next = CW'(wcount);
                    if (!in_win)
                    begin
                        rv_next   = 1'b1;
                        rst_next  = 1'b1;
                        rm_next   = 1'b0;
                        rmb_next  = '0;
                        rnb_next  = cmd.block_number;
                        rdup_next = dup_reg;
                    end
                    else
                    begin
                        case (ddrt_pkg::opcode_t'(cmd.opcode))
                            ddrt_pkg::OP_LOAD:
                            begin
                                crc_start  = 1'b1;
                                state_next = S_CRC;
                            end
                            ddrt_pkg::OP_LINK:
                            begin
                                treq.ent_re    = 1'b1;
                                treq.ent_raddr = offs[IW-1:0];
                                treq.nxt_re    = 1'b1;
                                treq.nxt_raddr = offs[IW-1:0];
                                state_next     = S_SELF;
                            end
                            ddrt_pkg::OP_UPDATE:
                            begin
                                treq.nxt_re    = 1'b1;
                                treq.nxt_raddr = offs[IW-1:0];
                                state_next     = S_U_CHK;
                            end
                            default:
                            begin
                                treq.nxt_re    = 1'b1;
                                treq.nxt_raddr = offs[IW-1:0];
                                state_next     = S_Q_WAIT;
                            end
                        endcase
                    end
                end
            end
            S_CRC:
            begin
                if (crc_done)
                begin
                    treq.ent_we           = 1'b1;
                    treq.ent_waddr        = idx_reg;
                    treq.ent_wdata.valid  = 1'b1;
                    treq.ent_wdata.crc    = crc_val;
                    treq.ent_wdata.digest = dig_reg;
                    if (op_reg == ddrt_pkg::OP_LOAD)
                    begin
                        treq.nxt_we    = 1'b1;
                        treq.nxt_waddr = idx_reg;
                        treq.nxt_wdata = idx_reg;
                        rv_next        = 1'b1;
                        rst_next       = 1'b0;
                        rm_next        = 1'b0;
                        rmb_next       = '0;
                        rnb_next       = ws_reg + BW'(idx_reg);
                        rdup_next      = dup_reg;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        sv_next    = 1'b1;
                        scrc_next  = crc_val;
                        sdig_next  = dig_reg;
                        jis_next   = '0;
                        pend_next  = 1'b0;
                        lim_next   = cnt_reg;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SELF:
            begin
                sv_next    = trsp.ent_rdata.valid;
                scrc_next  = trsp.ent_rdata.crc;
                sdig_next  = trsp.ent_rdata.digest;
                snext_next = trsp.nxt_rdata;
                jis_next   = '0;
                pend_next  = 1'b0;
                lim_next   = {1'b0, idx_reg};
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    mj_next        = pj_reg;
                    treq.nxt_re    = 1'b1;
                    treq.nxt_raddr = pj_reg;
                    state_next     = S_JOIN_WR;
                end
                else if (jis_reg < lim_reg)
                begin
                    treq.ent_re    = 1'b1;
                    treq.ent_raddr = jis_reg[IW-1:0];
                    pend_next      = 1'b1;
                    pj_next        = jis_reg[IW-1:0];
                    jis_next       = jis_reg + 1'b1;
                end
                else
                begin
                    // scan ran out without a match
                    rv_next    = 1'b1;
                    rst_next   = 1'b0;
                    rm_next    = 1'b0;
                    rmb_next   = '0;
                    rnb_next   = ws_reg + BW'(snext_reg);
                    rdup_next  = dup_reg;
                    state_next = S_IDLE;
                end
            end
            S_JOIN_WR:
            begin
                after_next     = trsp.nxt_rdata;
                treq.nxt_we    = 1'b1;
                treq.nxt_waddr = mj_reg;
                treq.nxt_wdata = idx_reg;
                state_next     = S_JOIN_WR2;
            end
            S_JOIN_WR2:
            begin
                treq.nxt_we    = 1'b1;
                treq.nxt_waddr = idx_reg;
                treq.nxt_wdata = after_reg;
                dup_next       = (dup_reg == ddrt_pkg::DUP_MAX) ? dup_reg : dup_reg + 1'b1;
                rv_next        = 1'b1;
                rst_next       = 1'b0;
                rm_next        = 1'b1;
                rmb_next       = ws_reg + BW'(mj_reg);
                rnb_next       = ws_reg + BW'(after_reg);
                rdup_next      = dup_next;
                state_next     = S_IDLE;
            end
            S_U_CHK:
            begin
                snext_next = trsp.nxt_rdata;
                if (trsp.nxt_rdata == idx_reg)
                begin
                    crc_start  = 1'b1;
                    state_next = S_CRC;
                end
                else
                begin
                    cur_next       = trsp.nxt_rdata;
                    walk_next      = IW'(1);
                    treq.nxt_re    = 1'b1;
                    treq.nxt_raddr = trsp.nxt_rdata;
                    state_next     = S_WALK;
                end
            end
            S_WALK:
            begin
                if (trsp.nxt_rdata == idx_reg)
                begin
                    treq.nxt_we    = 1'b1;
                    treq.nxt_waddr = cur_reg;
                    treq.nxt_wdata = snext_reg;
                    state_next     = S_UNL2;
                end
                else if (walk_reg == IW'(ddrt_pkg::ENTRIES - 1))
                begin
                    // broken ring: leave links as they are
                    crc_start  = 1'b1;
                    state_next = S_CRC;
                end
                else
                begin
                    cur_next       = trsp.nxt_rdata;
                    walk_next      = walk_reg + 1'b1;
                    treq.nxt_re    = 1'b1;
                    treq.nxt_raddr = trsp.nxt_rdata;
                end
            end
            S_UNL2:
            begin
                treq.nxt_we    = 1'b1;
                treq.nxt_waddr = idx_reg;
                treq.nxt_wdata = idx_reg;
                snext_next     = idx_reg;
                dup_next       = (dup_reg == '0) ? dup_reg : dup_reg - 1'b1;
                crc_start      = 1'b1;
                state_next     = S_CRC;
            end
            S_Q_WAIT:
            begin
                rv_next    = 1'b1;
                rst_next   = 1'b0;
                rm_next    = 1'b0;
                rmb_next   = '0;
                rnb_next   = ws_reg + BW'(trsp.nxt_rdata);
                rdup_next  = dup_reg;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            dup_reg   <= '0;
            rv_reg    <= 1'b0;
            ws_reg    <= '0;
            wc_reg    <= ddrt_pkg::WCNT_W'(1024);
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            dup_reg   <= dup_next;
            rv_reg    <= rv_next;
            if (cfg_we && (cfg_index == ddrt_pkg::CFG_WINDOW_START))
            begin
                ws_reg <= cfg_wdata;
            end
            if (cfg_we && (cfg_index == ddrt_pkg::CFG_WINDOW_COUNT))
            begin
                wc_reg <= cfg_wdata[ddrt_pkg::WCNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        idx_reg   <= idx_next;
        dig_reg   <= dig_next;
        sv_reg    <= sv_next;
        scrc_reg  <= scrc_next;
        sdig_reg  <= sdig_next;
        snext_reg <= snext_next;
        jis_reg   <= jis_next;
        lim_reg   <= lim_next;
        cnt_reg   <= cnt_next;
        pend_reg  <= pend_next;
        pj_reg    <= pj_next;
        mj_reg    <= mj_next;
        after_reg <= after_next;
        cur_reg   <= cur_next;
        walk_reg  <= walk_next;
        rst_reg   <= rst_next;
        rm_reg    <= rm_next;
        rmb_reg   <= rmb_next;
        rnb_reg   <= rnb_next;
        rdup_reg  <= rdup_next;
    end

    assign res.valid           = rv_reg;
    assign res.status          = rst_reg;
    assign res.match_found     = rm_reg;
    assign res.matched_block   = rmb_reg;
    assign res.next_block      = rnb_reg;
    assign res.duplicate_count = rdup_reg;

    `DDRT_ASSERT_IMPL(a_accept_idle, clk, rst_n, accept, state_reg == S_IDLE, "accept outside idle")
    `DDRT_ASSERT_IMPL(a_clear_block, clk, rst_n, state_reg == S_CLEAR, !cmd.ready, "ready during clear")
    `DDRT_ASSERT_IMPL(a_crc_state, clk, rst_n, crc_done, state_reg == S_CRC, "crc done unexpected")
    `DDRT_ASSERT_NEXT(a_join_result, clk, rst_n, state_reg == S_JOIN_WR2, res.valid, "join lost result")

endmodule
